/* src/dpid_pkg.sv */
`default_nettype none
package dpid_pkg;

  localparam int DPID_POS_BITS  = 20;
  localparam int DPID_FRAC_BITS = 20;

  localparam int GAIN_W  = 22;
  localparam int LIMIT_W = 20;
  localparam int INV_W   = 2;
  localparam int DRIVE_W = 8;
  localparam int SUM_W   = LIMIT_W + 1;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST = 22'd524288;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST = 22'd105;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST = 22'd419430;
  localparam logic [LIMIT_W-1:0] WINDOW_RST = 20'd200;
  localparam logic [LIMIT_W-1:0] CLAMP_RST  = 20'd500000;
  localparam logic [INV_W-1:0]   INVERT_RST = 2'd0;

  localparam logic signed [DRIVE_W-1:0] DRIVE_MAX = 8'sd127;
  localparam logic signed [DRIVE_W-1:0] DRIVE_MIN = -8'sd127;

  // stage load strobes shared by both lanes
  typedef struct packed {
    logic ld1;
    logic ld2;
    logic ld3;
  } dpid_ctl_t;

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive;
    logic                      clip;
  } dpid_res_t;

endpackage
`default_nettype wire

/* src/dpid_if.sv */
`default_nettype none
interface dpid_in_if #(
  parameter int POSITION_BITS = dpid_pkg::DPID_POS_BITS
);
  logic                            valid;
  logic                            ready;
  logic signed [POSITION_BITS-1:0] target_left;
  logic signed [POSITION_BITS-1:0] target_right;
  logic signed [POSITION_BITS-1:0] measured_left;
  logic signed [POSITION_BITS-1:0] measured_right;

  modport source (
    output valid, target_left, target_right, measured_left, measured_right,
    input  ready
  );
  modport sink (
    input  valid, target_left, target_right, measured_left, measured_right,
    output ready
  );
endinterface

interface dpid_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] drive_left;
  logic signed [7:0] drive_right;
  logic [1:0]        saturated;

  modport source (
    output valid, drive_left, drive_right, saturated,
    input  ready
  );
  modport sink (
    input  valid, drive_left, drive_right, saturated,
    output ready
  );
endinterface
`default_nettype wire

/* src/dpid_lane.sv */
`default_nettype none
module dpid_lane
  import dpid_pkg::*;
#(
  parameter int POSITION_BITS      = DPID_POS_BITS,
  parameter int GAIN_FRACTION_BITS = DPID_FRAC_BITS
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  dpid_ctl_t                       ctl_i,
  input  wire signed [POSITION_BITS-1:0]  target_i,
  input  wire signed [POSITION_BITS-1:0]  measured_i,
  input  wire        [GAIN_W-1:0]         gain_p_i,
  input  wire        [GAIN_W-1:0]         gain_i_i,
  input  wire        [GAIN_W-1:0]         gain_d_i,
  input  wire        [LIMIT_W-1:0]        window_i,
  input  wire        [LIMIT_W-1:0]        clamp_i,
  input  wire                             invert_i,
  output dpid_res_t                       res_o
);

  localparam int P   = POSITION_BITS;
  localparam int EW  = (P + 1 > SUM_W) ? P + 1 : SUM_W;
  localparam int PPW = P + 1 + GAIN_W + 1;
  localparam int PIW = SUM_W + GAIN_W + 1;
  localparam int PDW = P + 2 + GAIN_W + 1;
  localparam int TW  = ((PDW > PIW) ? PDW : PIW) + 2;

  // stage 1: error, windowed integral, derivative
  logic signed [P:0]       err_d;
  logic signed [EW-1:0]    err_ext;
  logic        [EW-1:0]    err_mag;
  logic                    in_win;
  logic signed [SUM_W:0]   sum_add;
  logic signed [SUM_W:0]   lim;
  logic signed [SUM_W-1:0] sum_d;
  logic signed [P+1:0]     dif_d;

  // err_q doubles as the previous error and sum_q as the integral state
  logic signed [P:0]       err_q;
  logic signed [SUM_W-1:0] sum_q;
  logic signed [P+1:0]     dif_q;

  assign err_d   = (P + 1)'(target_i) - (P + 1)'(measured_i);
  assign err_ext = EW'(err_d);
  assign err_mag = err_ext[EW-1] ? EW'(-err_ext) : EW'(err_ext);
  assign in_win  = (err_d != '0) && (err_mag < EW'(window_i));
  assign sum_add = (SUM_W + 1)'(sum_q) + (SUM_W + 1)'($signed(err_ext[SUM_W-1:0]));
  assign lim     = $signed({2'b00, clamp_i});

  always_comb begin
    if (!in_win) begin
      sum_d = '0;
    end else if (sum_add > lim) begin
      sum_d = lim[SUM_W-1:0];
    end else if (sum_add < -lim) begin
      sum_d = SUM_W'(-lim);
    end else begin
      sum_d = sum_add[SUM_W-1:0];
    end
  end

  assign dif_d = (P + 2)'(err_d) - (P + 2)'(err_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q <= '0;
      sum_q <= '0;
    end else if (ctl_i.ld1) begin
      err_q <= err_d;
      sum_q <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld1) begin
      dif_q <= dif_d;
    end
  end

  // stage 2: the three gain products
  logic signed [PPW-1:0] pp_q;
  logic signed [PIW-1:0] pi_q;
  logic signed [PDW-1:0] pd_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      pp_q <= $signed({1'b0, gain_p_i}) * err_q;
      pi_q <= $signed({1'b0, gain_i_i}) * sum_q;
      pd_q <= $signed({1'b0, gain_d_i}) * dif_q;
    end
  end

  // stage 3: sum, scale toward zero, invert, saturate
  logic signed [TW-1:0] total;
  logic        [TW-1:0] tot_mag;
  logic        [TW-1:0] scaled;
  logic                 neg;
  logic                 clip;
  logic        [7:0]    lo;
  dpid_res_t            res_d;
  dpid_res_t            res_q;

  assign total   = TW'(pp_q) + TW'(pi_q) + TW'(pd_q);
  assign tot_mag = total[TW-1] ? TW'(-total) : TW'(total);
  assign scaled  = tot_mag >> GAIN_FRACTION_BITS;
  assign neg     = total[TW-1] ^ invert_i;
  assign clip    = scaled > TW'(127);
  assign lo      = scaled[7:0];

  always_comb begin
    res_d.clip = clip;
    if (clip) begin
      res_d.drive = neg ? DRIVE_MIN : DRIVE_MAX;
    end else begin
      res_d.drive = neg ? $signed(-lo) : $signed(lo);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld3) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule
`default_nettype wire

/* src/dpid_merge.sv */
`default_nettype none
module dpid_merge
  import dpid_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        valid_i,
  output logic       ready_o,
  input  dpid_res_t  left_i,
  input  dpid_res_t  right_i,
  dpid_out_if.source out_o
);

  typedef struct packed {
    logic signed [DRIVE_W-1:0] drive_left;
    logic signed [DRIVE_W-1:0] drive_right;
    logic [1:0]                saturated;
  } dpid_beat_t;

  dpid_beat_t beat_in;
  dpid_beat_t out_q, out_d;
  dpid_beat_t skid_q, skid_d;
  logic       out_valid_q, out_valid_d;
  logic       skid_valid_q, skid_valid_d;
  logic       push, pop;

  assign beat_in.drive_left  = left_i.drive;
  assign beat_in.drive_right = right_i.drive;
  assign beat_in.saturated   = {right_i.clip, left_i.clip};

  assign ready_o = !skid_valid_q;
  assign push    = valid_i && !skid_valid_q;
  assign pop     = out_valid_q && out_o.ready;

  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (pop || !out_valid_q) begin
      out_d        = skid_valid_q ? skid_q : beat_in;
      out_valid_d  = skid_valid_q || push;
      skid_valid_d = 1'b0;
    end else if (push) begin
      skid_d       = beat_in;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.drive_left  = out_q.drive_left;
  assign out_o.drive_right = out_q.drive_right;
  assign out_o.saturated   = out_q.saturated;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid holds a beat while the output slot is empty");

  a_stall_fills_skid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && out_valid_q && !pop) |=> skid_valid_q)
    else $error("beat taken during a stall was not parked");

  a_drain_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !skid_valid_q && !push) |=> !out_valid_q)
    else $error("output still valid after last beat left");

endmodule
`default_nettype wire

/* src/dual_pid_position_controller_core.sv */
`default_nettype none
// Two-channel PID position controller. Each input beat carries target and
// measured positions for the left and right channels; each yields one output
// beat with the two saturated drives and their clip flags. The channels run
// in two identical lanes of three stages (error and integral update, gain
// products, scale and saturate) followed by a two-beat output skid, so one
// beat is taken every cycle unless the output stalls; its result passes the
// stage and merge output registers before it is valid. Registers are written
// over the APB port at 4*index; write them only while no beat is in flight.
module dual_pid_position_controller_core
  import dpid_pkg::*;
#(
  parameter int POSITION_BITS      = DPID_POS_BITS,
  parameter int GAIN_FRACTION_BITS = DPID_FRAC_BITS
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [4:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  dpid_in_if.sink     in_i,
  dpid_out_if.source  out_o
);

  typedef enum logic [2:0] {
    REG_GAIN_P  = 3'd0,
    REG_GAIN_I  = 3'd1,
    REG_GAIN_D  = 3'd2,
    REG_WINDOW  = 3'd3,
    REG_CLAMP   = 3'd4,
    REG_INVERT  = 3'd5
  } reg_idx_e;

  logic [GAIN_W-1:0]  gain_p_q, gain_i_q, gain_d_q;
  logic [LIMIT_W-1:0] window_q, clamp_q;
  logic [INV_W-1:0]   invert_q;
  logic               apb_wr;
  reg_idx_e           reg_idx;

  assign pready  = 1'b1;
  assign apb_wr  = psel && penable && pwrite;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q <= GAIN_P_RST;
      gain_i_q <= GAIN_I_RST;
      gain_d_q <= GAIN_D_RST;
      window_q <= WINDOW_RST;
      clamp_q  <= CLAMP_RST;
      invert_q <= INVERT_RST;
    end else if (apb_wr) begin
      case (reg_idx)
        REG_GAIN_P: gain_p_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_I: gain_i_q <= pwdata[GAIN_W-1:0];
        REG_GAIN_D: gain_d_q <= pwdata[GAIN_W-1:0];
        REG_WINDOW: window_q <= pwdata[LIMIT_W-1:0];
        REG_CLAMP:  clamp_q  <= pwdata[LIMIT_W-1:0];
        REG_INVERT: invert_q <= pwdata[INV_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GAIN_P: prdata = 32'(gain_p_q);
      REG_GAIN_I: prdata = 32'(gain_i_q);
      REG_GAIN_D: prdata = 32'(gain_d_q);
      REG_WINDOW: prdata = 32'(window_q);
      REG_CLAMP:  prdata = 32'(clamp_q);
      REG_INVERT: prdata = 32'(invert_q);
      default:    prdata = '0;
    endcase
  end

  // pipeline occupancy, common to both lanes
  logic      v1_q, v2_q, v3_q;
  logic      free1, free2, free3;
  logic      mrg_rdy;
  dpid_ctl_t ctl;

  assign free3   = !v3_q || mrg_rdy;
  assign free2   = !v2_q || free3;
  assign free1   = !v1_q || free2;
  assign ctl.ld1 = in_i.valid && free1;
  assign ctl.ld2 = v1_q && free2;
  assign ctl.ld3 = v2_q && free3;
  assign in_i.ready = free1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= ctl.ld1 || (v1_q && !ctl.ld2);
      v2_q <= ctl.ld2 || (v2_q && !ctl.ld3);
      v3_q <= ctl.ld3 || (v3_q && !mrg_rdy);
    end
  end

  dpid_res_t res_l, res_r;

  dpid_lane #(
    .POSITION_BITS      (POSITION_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_lane_l (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .target_i   (in_i.target_left),
    .measured_i (in_i.measured_left),
    .gain_p_i   (gain_p_q),
    .gain_i_i   (gain_i_q),
    .gain_d_i   (gain_d_q),
    .window_i   (window_q),
    .clamp_i    (clamp_q),
    .invert_i   (invert_q[0]),
    .res_o      (res_l)
  );

  dpid_lane #(
    .POSITION_BITS      (POSITION_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_lane_r (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .target_i   (in_i.target_right),
    .measured_i (in_i.measured_right),
    .gain_p_i   (gain_p_q),
    .gain_i_i   (gain_i_q),
    .gain_d_i   (gain_d_q),
    .window_i   (window_q),
    .clamp_i    (clamp_q),
    .invert_i   (invert_q[1]),
    .res_o      (res_r)
  );

  dpid_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .ready_o (mrg_rdy),
    .left_i  (res_l),
    .right_i (res_r),
    .out_o   (out_o)
  );

endmodule
`default_nettype wire
